FILE: hdl/ipbf_pkg.sv
// Package with shared types and constants for the IPv4 source blocklist filter.
`default_nettype none
package ipbf_pkg;
  localparam int BlockEntriesDef = 32;
  localparam int AllowEntriesDef = 32;
  localparam int AddrW  = 32;
  localparam int LimW   = 4;
  localparam int SecW   = 17;
  localparam int CntOutW = 6;
  localparam logic [LimW-1:0] LimitMax  = 4'd10;
  localparam logic [SecW-1:0] SecondsMax = 17'd100000;
  localparam logic [3:0] Ipv4Version = 4'd4;

  typedef enum logic [2:0] {
    MODE_CHECK     = 3'd0,
    MODE_BLOCK_ADD = 3'd1,
    MODE_ALLOW_ADD = 3'd2,
    MODE_BLOCK_DEL = 3'd3,
    MODE_ALLOW_DEL = 3'd4,
    MODE_TICK      = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_NOT_FOUND = 2'd2, ST_LOCAL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_NET0_ADDR = 3'd0, CFG_NET0_MASK = 3'd1, CFG_NET0_VALID = 3'd2,
    CFG_NET1_ADDR = 3'd3, CFG_NET1_MASK = 3'd4, CFG_NET1_VALID = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WAIT, S_APPLY, S_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // capture the accepted item, reset scan
    logic step;    // advance the scan by one entry
    logic apply;   // perform the update and form the result
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last;  // the entry now being presented is the last of both stores
  } sts_t;
endpackage
`default_nettype wire

FILE: hdl/ipbf_datapath.sv
// Datapath of the filter: entry stores, sequential scan and update logic.
`default_nettype none
module ipbf_datapath import ipbf_pkg::*; #(
  parameter int BLOCK_ENTRIES = BlockEntriesDef,
  parameter int ALLOW_ENTRIES = AllowEntriesDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  input  wire logic [2:0]        in_mode,
  input  wire logic [AddrW-1:0]  in_source_address,
  input  wire logic [3:0]        in_ip_version,
  input  wire logic [7:0]        in_repeat_limit,
  input  wire logic [16:0]       in_hold_seconds,
  input  wire logic              local_hit,
  output logic                   res_drop,
  output logic [1:0]             res_status,
  output logic [CntOutW-1:0]     res_block_entries,
  output logic [CntOutW-1:0]     res_allow_entries
);
  localparam int BIW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
  localparam int AIW = (ALLOW_ENTRIES > 1) ? $clog2(ALLOW_ENTRIES) : 1;
  localparam int BCW = $clog2(BLOCK_ENTRIES + 1);
  localparam int ACW = $clog2(ALLOW_ENTRIES + 1);
  localparam int MAXE = (BLOCK_ENTRIES > ALLOW_ENTRIES) ? BLOCK_ENTRIES : ALLOW_ENTRIES;
  localparam int PW = $clog2(MAXE + 1);

  // Stores: address and attributes in memories, valid bits in flops.
  logic [AddrW-1:0] b_addr_mem [BLOCK_ENTRIES];
  logic [LimW-1:0]  b_lim_mem  [BLOCK_ENTRIES];
  logic [LimW-1:0]  b_cnt_mem  [BLOCK_ENTRIES];
  logic [SecW-1:0]  b_sec_mem  [BLOCK_ENTRIES];
  logic [AddrW-1:0] a_addr_mem [ALLOW_ENTRIES];
  logic [BLOCK_ENTRIES-1:0] b_valid_r, b_valid_nxt;
  logic [ALLOW_ENTRIES-1:0] a_valid_r, a_valid_nxt;
  logic [BCW-1:0] b_used_r, b_used_nxt;
  logic [ACW-1:0] a_used_r, a_used_nxt;

  // Captured item.
  logic [2:0]       mode_r;
  logic [AddrW-1:0] src_r;
  logic [3:0]       ver_r;
  logic [LimW-1:0]  lim_r;
  logic [SecW-1:0]  sec_r;
  logic             local_r;

  // Scan pointer and registered read data.
  logic [PW-1:0]    ptr_r;
  logic             rd_v_r;          // read data below belongs to a valid scan slot
  logic [PW-1:0]    rd_idx_r;
  logic [AddrW-1:0] rd_baddr_r, rd_aaddr_r;
  logic [LimW-1:0]  rd_blim_r, rd_bcnt_r;
  logic [SecW-1:0]  rd_bsec_r;

  // Scan results.
  logic          b_hit_r, a_hit_r, b_free_f_r, a_free_f_r;
  logic [BIW-1:0] b_hit_idx_r, b_free_r;
  logic [AIW-1:0] a_hit_idx_r, a_free_r;
  logic [LimW-1:0] b_hit_lim_r, b_hit_cnt_r;
  // Tick walk: write-back of one decremented entry per slot.
  logic           tk_we;
  logic [SecW-1:0] tk_sec;

  logic [BIW-1:0] rd_bi;
  logic [AIW-1:0] rd_ai;
  logic [BIW-1:0] ptr_bi;
  logic [AIW-1:0] ptr_ai;
  logic rd_in_b, rd_in_a, ptr_in_b, ptr_in_a;
  logic [LimW-1:0] lim_sat;
  logic [SecW-1:0] sec_sat;

  assign ptr_bi = ptr_r[BIW-1:0];
  assign ptr_ai = ptr_r[AIW-1:0];
  assign rd_bi  = rd_idx_r[BIW-1:0];
  assign rd_ai  = rd_idx_r[AIW-1:0];
  assign ptr_in_b = (ptr_r < PW'(BLOCK_ENTRIES));
  assign ptr_in_a = (ptr_r < PW'(ALLOW_ENTRIES));
  assign rd_in_b  = rd_v_r && (rd_idx_r < PW'(BLOCK_ENTRIES));
  assign rd_in_a  = rd_v_r && (rd_idx_r < PW'(ALLOW_ENTRIES));
  assign sts.scan_last = (ptr_r == PW'(MAXE - 1));

  assign lim_sat = (in_repeat_limit > 8'(LimitMax)) ? LimitMax : in_repeat_limit[LimW-1:0];
  assign sec_sat = (in_hold_seconds > SecondsMax) ? SecondsMax : in_hold_seconds;

  logic rb_valid, ra_valid, b_match, a_match;
  assign rb_valid = rd_in_b && b_valid_r[rd_bi];
  assign ra_valid = rd_in_a && a_valid_r[rd_ai];
  assign b_match  = rb_valid && (rd_baddr_r == src_r);
  assign a_match  = ra_valid && (rd_aaddr_r == src_r);

  always_comb begin
    tk_we  = 1'b0;
    tk_sec = rd_bsec_r - 1'b1;
    if (mode_r == MODE_TICK && rb_valid && rd_bsec_r != '0) tk_we = 1'b1;
  end

  // Memory reads, one entry per cycle; tick write-back at the registered index.
  always_ff @(posedge clk) begin
    if (ptr_in_b) begin
      rd_baddr_r <= b_addr_mem[ptr_bi];
      rd_blim_r  <= b_lim_mem[ptr_bi];
      rd_bcnt_r  <= b_cnt_mem[ptr_bi];
      rd_bsec_r  <= b_sec_mem[ptr_bi];
    end
    if (ptr_in_a) rd_aaddr_r <= a_addr_mem[ptr_ai];
    if (tk_we) b_sec_mem[rd_bi] <= tk_sec;
    if (cmd.apply) begin
      unique case (mode_r)
        MODE_BLOCK_ADD: begin
          if (!local_r) begin
            if (b_hit_r) begin
              b_lim_mem[b_hit_idx_r] <= lim_r;
              b_sec_mem[b_hit_idx_r] <= sec_r;
              b_cnt_mem[b_hit_idx_r] <=
                ((b_hit_cnt_r + 1'b1) >= lim_r) ? lim_r : b_hit_cnt_r + 1'b1;
            end else if (b_free_f_r) begin
              b_addr_mem[b_free_r] <= src_r;
              b_lim_mem[b_free_r]  <= lim_r;
              b_sec_mem[b_free_r]  <= sec_r;
              b_cnt_mem[b_free_r]  <= LimW'(1);
            end
          end
        end
        MODE_ALLOW_ADD: if (!a_hit_r && a_free_f_r) a_addr_mem[a_free_r] <= src_r;
        default: ;
      endcase
    end
  end

  // Capture, scan bookkeeping and payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      src_r   <= in_source_address;
      ver_r   <= in_ip_version;
      lim_r   <= lim_sat;
      sec_r   <= sec_sat;
      local_r <= local_hit;
      b_hit_r <= 1'b0; a_hit_r <= 1'b0;
      b_free_f_r <= 1'b0; a_free_f_r <= 1'b0;
      b_hit_idx_r <= '0; a_hit_idx_r <= '0; b_free_r <= '0; a_free_r <= '0;
      b_hit_lim_r <= '0; b_hit_cnt_r <= '0;
    end else if (rd_v_r) begin
      if (b_match && !b_hit_r) begin
        b_hit_r <= 1'b1; b_hit_idx_r <= rd_bi;
        b_hit_lim_r <= rd_blim_r; b_hit_cnt_r <= rd_bcnt_r;
      end
      if (a_match && !a_hit_r) begin
        a_hit_r <= 1'b1; a_hit_idx_r <= rd_ai;
      end
      if (rd_in_b && !b_valid_r[rd_bi] && !b_free_f_r) begin
        b_free_f_r <= 1'b1; b_free_r <= rd_bi;
      end
      if (rd_in_a && !a_valid_r[rd_ai] && !a_free_f_r) begin
        a_free_f_r <= 1'b1; a_free_r <= rd_ai;
      end
    end
    rd_idx_r <= ptr_r;
    if (cmd.apply) begin
      res_drop   <= (mode_r == MODE_CHECK) && (ver_r == Ipv4Version) && !a_hit_r &&
                    b_hit_r && (b_hit_cnt_r >= b_hit_lim_r);
      res_status <= ST_OK;
      unique case (mode_r)
        MODE_BLOCK_ADD:
          if (local_r) res_status <= ST_LOCAL;
          else if (!b_hit_r && b_used_r >= BCW'(BLOCK_ENTRIES)) res_status <= ST_FULL;
        MODE_ALLOW_ADD:
          if (!a_hit_r && a_used_r >= ACW'(ALLOW_ENTRIES)) res_status <= ST_FULL;
        MODE_BLOCK_DEL: if (!b_hit_r) res_status <= ST_NOT_FOUND;
        MODE_ALLOW_DEL: if (!a_hit_r) res_status <= ST_NOT_FOUND;
        default: ;
      endcase
      res_block_entries <= CntOutW'(b_used_nxt);
      res_allow_entries <= CntOutW'(a_used_nxt);
    end
  end

  // Control state: valid bits, fill counts, scan pointer.
  always_comb begin
    b_valid_nxt = b_valid_r;
    a_valid_nxt = a_valid_r;
    b_used_nxt  = b_used_r;
    a_used_nxt  = a_used_r;
    if (tk_we && tk_sec == '0) begin
      b_valid_nxt[rd_bi] = 1'b0;
      b_used_nxt = b_used_r - 1'b1;
    end
    if (cmd.apply) begin
      unique case (mode_r)
        MODE_BLOCK_ADD:
          if (!local_r && !b_hit_r && b_free_f_r) begin
            b_valid_nxt[b_free_r] = 1'b1; b_used_nxt = b_used_r + 1'b1;
          end
        MODE_ALLOW_ADD:
          if (!a_hit_r && a_free_f_r) begin
            a_valid_nxt[a_free_r] = 1'b1; a_used_nxt = a_used_r + 1'b1;
          end
        MODE_BLOCK_DEL:
          if (b_hit_r) begin
            b_valid_nxt[b_hit_idx_r] = 1'b0; b_used_nxt = b_used_r - 1'b1;
          end
        MODE_ALLOW_DEL:
          if (a_hit_r) begin
            a_valid_nxt[a_hit_idx_r] = 1'b0; a_used_nxt = a_used_r - 1'b1;
          end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= '0; a_valid_r <= '0;
      b_used_r <= '0; a_used_r <= '0;
      ptr_r <= '0; rd_v_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt; a_valid_r <= a_valid_nxt;
      b_used_r <= b_used_nxt; a_used_r <= a_used_nxt;
      rd_v_r <= cmd.step;
      if (cmd.load) ptr_r <= '0;
      else if (cmd.step) ptr_r <= ptr_r + 1'b1;
    end
  end

  // The fill counts always equal the number of set valid bits.
  a_bcount: assert property (@(posedge clk) disable iff (!rst_n)
    32'(b_used_r) == 32'($countones(b_valid_r)))
    else $error("blocklist fill count out of step with valid bits");
  a_acount: assert property (@(posedge clk) disable iff (!rst_n)
    32'(a_used_r) == 32'($countones(a_valid_r)))
    else $error("allowlist fill count out of step with valid bits");
  a_nostep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> !cmd.step && !rd_v_r)
    else $error("update issued while scan still running");
endmodule
`default_nettype wire

FILE: hdl/ipbf_ctrl.sv
// Controller state machine sequencing scan, update and result transfer.
`default_nettype none
module ipbf_ctrl import ipbf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd,
  input  wire sts_t sts
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_last) state_nxt = S_WAIT;
      end
      S_WAIT: state_nxt = S_APPLY;
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_onecmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step, cmd.apply}))
    else $error("controller issued more than one command");
  a_apply_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> out_valid)
    else $error("result not presented after update");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while result pending");
endmodule
`default_nettype wire

FILE: hdl/ip_source_blocklist_filter_top.sv
// Top level of the IPv4 source blocklist and allowlist filter.
// Usage: one operation per input transfer on in_valid/in_ready (mode, source
// address, version nibble, repeat limit, hold time). Modes are packet check,
// block add, allow add, block delete, allow delete and a once-per-second tick.
// Each input transfer yields exactly one result transfer on out_valid/out_ready
// carrying drop, status and the fill counts of both stores after the operation.
// Every operation walks both stores one entry per cycle through the single read
// port of the entry memories, then passes through a wait and an update state
// before it presents the result. The block handles one item at a time. A
// stalled receiver holds the result steady and keeps in_ready low until the
// result transfer completes. Synchronous reset empties both stores at once
// through their valid bits and clears the configuration registers. The local
// subnet registers are to be written through cfg_we/cfg_index/cfg_data only
// while idle; the block itself does not enforce this.
`default_nettype none
module ip_source_blocklist_filter_top import ipbf_pkg::*; #(
  parameter int BLOCK_ENTRIES = BlockEntriesDef,
  parameter int ALLOW_ENTRIES = AllowEntriesDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_mode,
  input  wire logic [31:0]       in_source_address,
  input  wire logic [3:0]        in_ip_version,
  input  wire logic [7:0]        in_repeat_limit,
  input  wire logic [16:0]       in_hold_seconds,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_drop,
  output logic [1:0]             out_status,
  output logic [5:0]             out_block_entries,
  output logic [5:0]             out_allow_entries
);
  logic [31:0] net0_addr_r, net0_mask_r, net1_addr_r, net1_mask_r;
  logic        net0_valid_r, net1_valid_r;
  logic        local_hit;
  cmd_t cmd;
  sts_t sts;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      net0_addr_r <= '0; net0_mask_r <= '0; net0_valid_r <= 1'b0;
      net1_addr_r <= '0; net1_mask_r <= '0; net1_valid_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NET0_ADDR:  net0_addr_r  <= cfg_data;
        CFG_NET0_MASK:  net0_mask_r  <= cfg_data;
        CFG_NET0_VALID: net0_valid_r <= cfg_data[0];
        CFG_NET1_ADDR:  net1_addr_r  <= cfg_data;
        CFG_NET1_MASK:  net1_mask_r  <= cfg_data;
        CFG_NET1_VALID: net1_valid_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A source inside either valid local subnet is never added to the blocklist.
  assign local_hit =
    (net0_valid_r && (((net0_addr_r ^ in_source_address) & net0_mask_r) == '0)) ||
    (net1_valid_r && (((net1_addr_r ^ in_source_address) & net1_mask_r) == '0));

  ipbf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
  );

  ipbf_datapath #(.BLOCK_ENTRIES(BLOCK_ENTRIES), .ALLOW_ENTRIES(ALLOW_ENTRIES)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_mode, .in_source_address, .in_ip_version, .in_repeat_limit, .in_hold_seconds,
    .local_hit,
    .res_drop(out_drop), .res_status(out_status),
    .res_block_entries(out_block_entries), .res_allow_entries(out_allow_entries)
  );
endmodule
`default_nettype wire
